// ===== sv/priority_task_scheduler_macros.svh =====
// Assertion macros used by the scheduler RTL.
`ifndef PRIORITY_TASK_SCHEDULER_MACROS_SVH
`define PRIORITY_TASK_SCHEDULER_MACROS_SVH
`ifndef SYNTHESIS
`define PTS_ASSERT(label, clk, rst_n, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);
`define PTS_ASSERT_IMPL(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);
`define PTS_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);
`else
`define PTS_ASSERT(label, clk, rst_n, prop, msg)
`define PTS_ASSERT_IMPL(label, clk, rst_n, ante, cons, msg)
`define PTS_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg)
`endif
`endif

// ===== sv/pts_pkg.sv =====
// Types and constants shared by the priority task scheduler.
`timescale 1ns / 1ps
package pts_pkg;

    localparam int ID_W       = 8;
    localparam int PRIO_W     = 8;
    localparam int BURST_W    = 16;
    localparam int CLK_W      = 32;
    localparam int SUM_W      = 38;
    localparam int AVG_W      = 39;
    localparam int DIVIDEND_W = 45;
    localparam int DIV_CNT_W  = 6;

    typedef enum logic {
        ACT_ADD   = 1'b0,
        ACT_SCHED = 1'b1
    } action_t;

    typedef enum logic [1:0] {
        SEL_TURN,
        SEL_WAIT,
        SEL_RESP
    } avg_sel_t;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_SCAN,
        ST_DRAIN,
        ST_DISPATCH,
        ST_ACCUM,
        ST_DIV_PREP,
        ST_DIV_START,
        ST_DIV_WAIT,
        ST_EMIT,
        ST_EMPTY
    } state_t;

    typedef struct packed {
        logic [ID_W-1:0]    id;
        logic [PRIO_W-1:0]  prio;
        logic [BURST_W-1:0] burst;
    } entry_t;

    typedef struct packed {
        logic                  start;
        logic [DIVIDEND_W-1:0] dividend;
    } div_req_t;

    typedef struct packed {
        logic             done;
        logic [AVG_W-1:0] quot;
    } div_rsp_t;

endpackage

// ===== sv/priority_task_scheduler.sv =====
// An add beat is accepted while the sequencer is idle. In a schedule run over n tasks, every
// dispatch scans all n slots of the run through the one table read port, and the run then
// computes the three averages, which share one divider that retires a quotient bit per cycle.
// An empty run loads its result once the output register is free.
// Reset clears the slot valid bits, fill count, clock, sequencer and output valid; the
// task table contents are not cleared.
`timescale 1ns / 1ps
`include "priority_task_scheduler_macros.svh"
module priority_task_scheduler #(
    parameter int MAX_TASKS = 32
) (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            in_valid,
    output logic                            in_ready,
    input  logic                            action,
    input  logic [pts_pkg::ID_W-1:0]        task_id,
    input  logic [pts_pkg::PRIO_W-1:0]      priority_req,
    input  logic [pts_pkg::BURST_W-1:0]     burst,
    output logic                            out_valid,
    input  logic                            out_ready,
    output logic [pts_pkg::ID_W-1:0]        out_task_id,
    output logic [pts_pkg::PRIO_W-1:0]      out_priority,
    output logic [pts_pkg::BURST_W-1:0]     out_burst,
    output logic [pts_pkg::CLK_W-1:0]       started_at,
    output logic [pts_pkg::CLK_W-1:0]       finished_at,
    output logic [pts_pkg::AVG_W-1:0]       avg_turnaround,
    output logic [pts_pkg::AVG_W-1:0]       avg_wait,
    output logic [pts_pkg::AVG_W-1:0]       avg_response,
    output logic                            last,
    output logic                            empty_res
);

    localparam int AW = (MAX_TASKS > 1) ? $clog2(MAX_TASKS) : 1;
    localparam int CW = $clog2(MAX_TASKS + 1);
    localparam int CLK_W = pts_pkg::CLK_W;
    localparam int SUM_W = pts_pkg::SUM_W;
    localparam int AVG_W = pts_pkg::AVG_W;
    localparam int DW    = pts_pkg::DIVIDEND_W;

    pts_pkg::state_t   state_reg, state_next;
    logic [CW-1:0]     fill_reg;
    logic [CW-1:0]     n_reg;
    logic [CW-1:0]     rem_reg;
    logic [MAX_TASKS-1:0] slot_valid_reg;
    logic [CLK_W-1:0]  clock_reg;
    logic [AW-1:0]     scan_idx_reg;
    logic              cmp_vld_reg;
    logic [AW-1:0]     cmp_idx_reg;
    logic              best_found_reg;
    pts_pkg::entry_t   best_reg;
    logic [AW-1:0]     best_idx_reg;
    logic              last_task_reg;
    logic [CLK_W-1:0]  res_start_reg, res_stop_reg, res_wait_reg;
    logic [SUM_W-1:0]  sum_exit_reg, sum_start_reg, sum_wait_reg;
    pts_pkg::avg_sel_t div_sel_reg;
    logic [DW-1:0]     dividend_reg;
    logic [AVG_W-1:0]  avg_turn_reg, avg_wait_reg, avg_resp_reg;
    logic              out_valid_reg;
    pts_pkg::entry_t   out_entry_reg;
    logic [CLK_W-1:0]  out_start_reg, out_stop_reg;
    logic [AVG_W-1:0]  out_turn_reg, out_wait_reg, out_resp_reg;
    logic              out_last_reg, out_empty_reg;

    // Sequencer strobes.
    logic in_acc, add_do, run_start, scan_init, issue, dispatch, accum;
    logic div_prep, div_capture, out_free, out_load_task, out_load_empty, run_done;

    pts_pkg::entry_t   wr_entry, rd_entry;
    pts_pkg::div_req_t div_req;
    pts_pkg::div_rsp_t div_rsp;
    logic              scan_end;
    logic              take;
    logic [CLK_W:0]    stop_sum;
    logic              stop_sat;
    logic [SUM_W-1:0]  avg_op;

    assign wr_entry = '{id: task_id, prio: priority_req, burst: burst};

    pts_slot_mem #(
        .DEPTH (MAX_TASKS),
        .AW    (AW)
    ) u_slot_mem (
        .clk     (clk),
        .wr_en   (add_do),
        .wr_addr (fill_reg[AW-1:0]),
        .wr_data (wr_entry),
        .rd_addr (scan_idx_reg),
        .rd_data (rd_entry)
    );

    pts_divider #(
        .DIV_W (CW)
    ) u_divider (
        .clk     (clk),
        .rst_n   (rst_n),
        .req     (div_req),
        .divisor (n_reg),
        .rsp     (div_rsp)
    );

    assign out_free = !out_valid_reg || out_ready;
    assign scan_end = CW'(scan_idx_reg) == (n_reg - CW'(1));
    assign take     = cmp_vld_reg && slot_valid_reg[cmp_idx_reg] &&
                      (!best_found_reg || (rd_entry.prio > best_reg.prio));
    assign stop_sum = {1'b0, clock_reg} + (CLK_W + 1)'(best_reg.burst);
    assign stop_sat = stop_sum[CLK_W];

    // Next state.
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            pts_pkg::ST_IDLE:
            begin
                if (in_valid && (action == pts_pkg::ACT_SCHED))
                begin
                    state_next = (fill_reg == '0) ? pts_pkg::ST_EMPTY : pts_pkg::ST_SCAN;
                end
            end
            pts_pkg::ST_SCAN:
            begin
                if (scan_end)
                begin
                    state_next = pts_pkg::ST_DRAIN;
                end
            end
            pts_pkg::ST_DRAIN:     state_next = pts_pkg::ST_DISPATCH;
            pts_pkg::ST_DISPATCH:  state_next = pts_pkg::ST_ACCUM;
            pts_pkg::ST_ACCUM:
            begin
                state_next = last_task_reg ? pts_pkg::ST_DIV_PREP : pts_pkg::ST_EMIT;
            end
            pts_pkg::ST_DIV_PREP:  state_next = pts_pkg::ST_DIV_START;
            pts_pkg::ST_DIV_START: state_next = pts_pkg::ST_DIV_WAIT;
            pts_pkg::ST_DIV_WAIT:
            begin
                if (div_rsp.done)
                begin
                    state_next = (div_sel_reg == pts_pkg::SEL_RESP) ?
                                 pts_pkg::ST_EMIT : pts_pkg::ST_DIV_PREP;
                end
            end
            pts_pkg::ST_EMIT:
            begin
                if (out_free)
                begin
                    state_next = last_task_reg ? pts_pkg::ST_IDLE : pts_pkg::ST_SCAN;
                end
            end
            pts_pkg::ST_EMPTY:
            begin
                if (out_free)
                begin
                    state_next = pts_pkg::ST_IDLE;
                end
            end
            default:               state_next = pts_pkg::ST_IDLE;
        endcase
    end

    // Sequencer outputs.
    always_comb
    begin
        in_ready         = 1'b0;
        issue            = 1'b0;
        dispatch         = 1'b0;
        accum            = 1'b0;
        div_prep         = 1'b0;
        div_req.start    = 1'b0;
        div_req.dividend = dividend_reg;
        div_capture      = 1'b0;
        out_load_task    = 1'b0;
        out_load_empty   = 1'b0;
        run_done         = 1'b0;
        scan_init        = 1'b0;
        case (state_reg)
            pts_pkg::ST_IDLE:      in_ready = 1'b1;
            pts_pkg::ST_SCAN:      issue = 1'b1;
            pts_pkg::ST_DISPATCH:  dispatch = 1'b1;
            pts_pkg::ST_ACCUM:     accum = 1'b1;
            pts_pkg::ST_DIV_PREP:  div_prep = 1'b1;
            pts_pkg::ST_DIV_START: div_req.start = 1'b1;
            pts_pkg::ST_DIV_WAIT:  div_capture = div_rsp.done;
            pts_pkg::ST_EMIT:
            begin
                out_load_task = out_free;
                run_done      = out_free && last_task_reg;
                scan_init     = out_free && !last_task_reg;
            end
            pts_pkg::ST_EMPTY:
            begin
                out_load_empty = out_free;
                run_done       = out_free;
            end
            default:               in_ready = 1'b0;
        endcase
        in_acc    = in_valid && in_ready;
        add_do    = in_acc && (action == pts_pkg::ACT_ADD) && (fill_reg < CW'(MAX_TASKS));
        run_start = in_acc && (action == pts_pkg::ACT_SCHED);
        if (run_start && (fill_reg != '0))
        begin
            scan_init = 1'b1;
        end
    end

    // Control state.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= pts_pkg::ST_IDLE;
            fill_reg       <= '0;
            slot_valid_reg <= '0;
            clock_reg      <= '0;
            cmp_vld_reg    <= 1'b0;
            best_found_reg <= 1'b0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            state_reg   <= state_next;
            cmp_vld_reg <= issue;
            if (add_do)
            begin
                slot_valid_reg[fill_reg[AW-1:0]] <= 1'b1;
                fill_reg <= fill_reg + CW'(1);
            end
            if (run_done)
            begin
                fill_reg <= '0;
            end
            if (scan_init)
            begin
                best_found_reg <= 1'b0;
            end
            else if (take)
            begin
                best_found_reg <= 1'b1;
            end
            if (dispatch)
            begin
                slot_valid_reg[best_idx_reg] <= 1'b0;
                clock_reg <= stop_sat ? '1 : stop_sum[CLK_W-1:0];
            end
            if (out_load_task || out_load_empty)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_comb
    begin
        case (div_sel_reg)
            pts_pkg::SEL_TURN: avg_op = sum_exit_reg;
            pts_pkg::SEL_WAIT: avg_op = sum_wait_reg;
            pts_pkg::SEL_RESP: avg_op = sum_start_reg;
            default:           avg_op = sum_exit_reg;
        endcase
    end

    // Datapath.
    always_ff @(posedge clk)
    begin
        if (run_start)
        begin
            n_reg         <= fill_reg;
            rem_reg       <= fill_reg;
            sum_exit_reg  <= '0;
            sum_start_reg <= '0;
            sum_wait_reg  <= '0;
            div_sel_reg   <= pts_pkg::SEL_TURN;
        end
        if (scan_init)
        begin
            scan_idx_reg <= '0;
        end
        else if (issue)
        begin
            scan_idx_reg <= scan_idx_reg + AW'(1);
        end
        cmp_idx_reg <= scan_idx_reg;
        if (take)
        begin
            best_reg     <= rd_entry;
            best_idx_reg <= cmp_idx_reg;
        end
        if (dispatch)
        begin
            res_start_reg <= clock_reg;
            res_stop_reg  <= stop_sat ? '1 : stop_sum[CLK_W-1:0];
            // Exit minus burst is the start time unless the exit saturated.
            res_wait_reg  <= stop_sat ?
                             {{(CLK_W - pts_pkg::BURST_W){1'b1}}, ~best_reg.burst} : clock_reg;
            rem_reg       <= rem_reg - CW'(1);
            last_task_reg <= rem_reg == CW'(1);
        end
        if (accum)
        begin
            sum_exit_reg  <= sum_exit_reg + SUM_W'(res_stop_reg);
            sum_start_reg <= sum_start_reg + SUM_W'(res_start_reg);
            sum_wait_reg  <= sum_wait_reg + SUM_W'(res_wait_reg);
        end
        if (div_prep)
        begin
            // Times one hundred as 64 + 32 + 4, with half the count for rounding.
            dividend_reg <= (DW'(avg_op) << 6) + (DW'(avg_op) << 5) + (DW'(avg_op) << 2) +
                            DW'(n_reg >> 1);
        end
        if (div_capture)
        begin
            case (div_sel_reg)
                pts_pkg::SEL_TURN:
                begin
                    avg_turn_reg <= div_rsp.quot;
                    div_sel_reg  <= pts_pkg::SEL_WAIT;
                end
                pts_pkg::SEL_WAIT:
                begin
                    avg_wait_reg <= div_rsp.quot;
                    div_sel_reg  <= pts_pkg::SEL_RESP;
                end
                default:
                begin
                    avg_resp_reg <= div_rsp.quot;
                end
            endcase
        end
        if (out_load_task)
        begin
            out_entry_reg <= best_reg;
            out_start_reg <= res_start_reg;
            out_stop_reg  <= res_stop_reg;
            out_turn_reg  <= last_task_reg ? avg_turn_reg : '0;
            out_wait_reg  <= last_task_reg ? avg_wait_reg : '0;
            out_resp_reg  <= last_task_reg ? avg_resp_reg : '0;
            out_last_reg  <= last_task_reg;
            out_empty_reg <= 1'b0;
        end
        else if (out_load_empty)
        begin
            out_entry_reg <= '0;
            out_start_reg <= '0;
            out_stop_reg  <= '0;
            out_turn_reg  <= '0;
            out_wait_reg  <= '0;
            out_resp_reg  <= '0;
            out_last_reg  <= 1'b1;
            out_empty_reg <= 1'b1;
        end
    end

    assign out_valid      = out_valid_reg;
    assign out_task_id    = out_entry_reg.id;
    assign out_priority   = out_entry_reg.prio;
    assign out_burst      = out_entry_reg.burst;
    assign started_at     = out_start_reg;
    assign finished_at    = out_stop_reg;
    assign avg_turnaround = out_turn_reg;
    assign avg_wait       = out_wait_reg;
    assign avg_response   = out_resp_reg;
    assign last           = out_last_reg;
    assign empty_res      = out_empty_reg;

    `PTS_ASSERT(a_fill_bound, clk, rst_n, fill_reg <= CW'(MAX_TASKS), "fill count beyond depth")
    `PTS_ASSERT(a_valid_count, clk, rst_n, $countones(slot_valid_reg) <= fill_reg, "valid bits exceed fill count")
    `PTS_ASSERT_IMPL(a_div_done, clk, rst_n, div_rsp.done, state_reg == pts_pkg::ST_DIV_WAIT, "divider finished outside its wait")
    `PTS_ASSERT_NEXT(a_run_clears, clk, rst_n, out_load_task && last_task_reg, slot_valid_reg == '0, "table not empty after run")

endmodule

// ===== sv/pts_slot_mem.sv =====
// Task table: one write port and one registered read port.
`timescale 1ns / 1ps
module pts_slot_mem #(
    parameter int DEPTH = 32,
    parameter int AW    = 5
) (
    input  logic            clk,
    input  logic            wr_en,
    input  logic [AW-1:0]   wr_addr,
    input  pts_pkg::entry_t wr_data,
    input  logic [AW-1:0]   rd_addr,
    output pts_pkg::entry_t rd_data
);

    pts_pkg::entry_t mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        rd_data <= mem[rd_addr];
    end

endmodule

// ===== sv/pts_divider.sv =====
// Restoring divider that retires one quotient bit per cycle.
`timescale 1ns / 1ps
module pts_divider #(
    parameter int DIV_W = 6
) (
    input  logic              clk,
    input  logic              rst_n,
    input  pts_pkg::div_req_t req,
    input  logic [DIV_W-1:0]  divisor,
    output pts_pkg::div_rsp_t rsp
);

    localparam int DW = pts_pkg::DIVIDEND_W;

    logic                          busy_reg;
    logic                          done_reg;
    logic [pts_pkg::DIV_CNT_W-1:0] cnt_reg;
    logic [DW-1:0]                 qd_reg;
    logic [DIV_W-1:0]              rem_reg;
    logic [DIV_W:0]                shift_val;
    logic [DIV_W:0]                diff_val;
    logic                          ge;

    // The dividend shifts out at the top while quotient bits enter at the bottom.
    assign shift_val = {rem_reg, qd_reg[DW-1]};
    assign ge        = shift_val >= {1'b0, divisor};
    assign diff_val  = shift_val - {1'b0, divisor};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (req.start)
            begin
                busy_reg <= 1'b1;
                cnt_reg  <= '0;
            end
            else if (busy_reg)
            begin
                cnt_reg <= cnt_reg + pts_pkg::DIV_CNT_W'(1);
                if (cnt_reg == pts_pkg::DIV_CNT_W'(DW - 1))
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (req.start)
        begin
            qd_reg  <= req.dividend;
            rem_reg <= '0;
        end
        else if (busy_reg)
        begin
            qd_reg  <= {qd_reg[DW-2:0], ge};
            rem_reg <= ge ? diff_val[DIV_W-1:0] : shift_val[DIV_W-1:0];
        end
    end

    assign rsp.done = done_reg;
    assign rsp.quot = qd_reg[pts_pkg::AVG_W-1:0];

endmodule
